### sv/ahe_pkg.sv
// Shared types, constants and the log2 fraction table function for the entropy block.
package ahe_pkg;

    localparam int MAX_TOKENS_DEF     = 4096;
    localparam int MAX_HEADS_DEF      = 64;
    localparam int LOG_TABLE_BITS_DEF = 8;

    localparam int TC_W   = 13;
    localparam int HC_W   = 7;
    localparam int THR_W  = 20;
    localparam int W_W    = 17;
    localparam int HN_W   = 6;
    localparam int ENT_W  = 20;
    localparam int SUM_W  = 34;
    localparam int NL_W   = 21;
    localparam int PROD_W = W_W + NL_W;
    localparam int TERM_W = PROD_W - 16;
    localparam int DCNT_W = 6;
    localparam int IDX_W  = 2;

    localparam logic [W_W-1:0]   ONE_Q16 = W_W'(65536);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [TC_W-1:0]  COLLAPSE_MIN_N = TC_W'(4);
    localparam logic [TC_W-1:0]  TC_RESET  = TC_W'(4);
    localparam logic [HC_W-1:0]  HC_RESET  = HC_W'(1);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(6554);

    localparam logic [IDX_W-1:0] REG_TOKEN_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEAD_COUNT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic log_en;
        logic mul_en;
        logic acc_en;
        logic div_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic head_end;
        logic div_done;
        logic out_free;
    } dp_status_t;

    // log2(1 + idx/2^bits) in Q0.16 by repeated squaring of a Q2.30 value
    function automatic logic [15:0] log_frac(input int idx, input int bits);
        logic [63:0] x;
        logic [15:0] res;
        x = (64'd1 << bits) + 64'(idx);
        x = x << (30 - bits);
        res = '0;
        for (int i = 15; i >= 0; i--)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                res[i] = 1'b1;
                x = x >> 1;
            end
        end
        return res;
    endfunction

endpackage

### sv/attention_head_entropy.sv
// Top level of the attention head entropy block: streaming ports, controller and datapath.
//  channel   | dir | handshake                   | payload
//  s_axis    | in  | s_tvalid / s_tready         | s_tdata: weight
//  m_axis    | out | m_tvalid / m_tready         | m_tdata: head_number, entropy, collapse_flag
//  cfg       | in  | cfg_valid / cfg_ready       | cfg_index, cfg_data
// An item steps through accept, log lookup, multiply and accumulate; s_tready is low meanwhile.
// The last item of a head then runs the bit-serial divider and loads the result register.
// rst_n is asynchronous: position counters, sum and valid flag clear; config registers return to defaults.
// The result register holds its item while m_tready is low; a new head end waits for it.
// cfg_ready is always high.
module attention_head_entropy #(
    parameter int MAX_TOKENS     = ahe_pkg::MAX_TOKENS_DEF,
    parameter int MAX_HEADS      = ahe_pkg::MAX_HEADS_DEF,
    parameter int LOG_TABLE_BITS = ahe_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // [16:0] weight
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [5:0] head_number, [25:6] entropy, [26] flag
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ahe_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ahe_pkg::THR_W-1:0]  cfg_data
);
    import ahe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [HN_W-1:0]  head_number;
    logic [ENT_W-1:0] entropy;
    logic             collapse_flag;

    assign cfg_ready = 1'b1;

    ahe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ahe_dp #(
        .MAX_TOKENS     (MAX_TOKENS),
        .MAX_HEADS      (MAX_HEADS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_value   (cfg_data),
        .in_weight   (s_tdata[W_W-1:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_head    (head_number),
        .out_entropy (entropy),
        .out_flag    (collapse_flag)
    );

    assign m_tdata = {5'b0, collapse_flag, entropy, head_number};

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !s_tready)
        else $error("input accepted while term pipeline busy");

    a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !s_tready)
        else $error("input ready during division");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("result valid without emit");
`endif

endmodule

### sv/ahe_ctrl.sv
// Sequencing state machine: term pipeline steps, head-end division and result hand-off.
module ahe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ahe_pkg::dp_status_t status,
    output ahe_pkg::dp_cmd_t   cmd
);
    import ahe_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_LOG;
            ST_LOG:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = status.head_end ? ST_DIV : ST_IDLE;
            ST_DIV:  if (status.div_done) state_next = ST_EMIT;
            ST_EMIT: if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_LOG:  cmd.log_en = 1'b1;
            ST_MUL:  cmd.mul_en = 1'b1;
            ST_ACC:  cmd.acc_en = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_EMIT: cmd.emit = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### sv/ahe_dp.sv
// Datapath: config registers, positions, log2 term, accumulator, divider and output register.
module ahe_dp #(
    parameter int MAX_TOKENS     = ahe_pkg::MAX_TOKENS_DEF,
    parameter int MAX_HEADS      = ahe_pkg::MAX_HEADS_DEF,
    parameter int LOG_TABLE_BITS = ahe_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ahe_pkg::dp_cmd_t            cmd,
    output ahe_pkg::dp_status_t         status,
    input  logic                        cfg_we,
    input  logic [ahe_pkg::IDX_W-1:0]   cfg_idx,
    input  logic [ahe_pkg::THR_W-1:0]   cfg_value,
    input  logic [ahe_pkg::W_W-1:0]     in_weight,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ahe_pkg::HN_W-1:0]    out_head,
    output logic [ahe_pkg::ENT_W-1:0]   out_entropy,
    output logic                        out_flag
);
    import ahe_pkg::*;

    localparam int PW       = $clog2(MAX_TOKENS) + 1;
    localparam int HW       = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
    localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;

    logic [TC_W-1:0]  tc_reg;
    logic [HC_W-1:0]  hc_reg;
    logic [THR_W-1:0] thr_reg;

    logic [PW-1:0]  key_reg, row_reg;
    logic [HW-1:0]  head_reg;
    logic [HN_W-1:0] head_out_reg;
    logic            head_end_reg;
    logic [W_W-1:0]  w_reg;
    logic [NL_W-1:0] nl_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  div_reg;
    logic [TC_W:0]     rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              oval_reg;
    logic [HN_W-1:0]   ohead_reg;
    logic [ENT_W-1:0]  oent_reg;
    logic              oflag_reg;

    logic [TC_W-1:0] n_eff;
    logic [HC_W-1:0] hc_eff;
    logic            key_last, row_last, head_last;
    logic [15:0]     log_tab [TAB_SIZE];

    for (genvar g = 0; g < TAB_SIZE; g++)
    begin : g_tab
        assign log_tab[g] = log_frac(g, LOG_TABLE_BITS);
    end

    always_comb
    begin
        if (tc_reg == '0)
            n_eff = TC_W'(1);
        else if (32'(tc_reg) > MAX_TOKENS)
            n_eff = TC_W'(MAX_TOKENS);
        else
            n_eff = tc_reg;
        if (hc_reg == '0)
            hc_eff = HC_W'(1);
        else if (32'(hc_reg) > MAX_HEADS)
            hc_eff = HC_W'(MAX_HEADS);
        else
            hc_eff = hc_reg;
    end

    assign key_last  = (32'(key_reg) + 1) >= 32'(n_eff);
    assign row_last  = (32'(row_reg) + 1) >= 32'(n_eff);
    assign head_last = (32'(head_reg) + 1) >= 32'(hc_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg  <= TC_RESET;
            hc_reg  <= HC_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_TOKEN_COUNT: tc_reg  <= cfg_value[TC_W-1:0];
                REG_HEAD_COUNT:  hc_reg  <= cfg_value[HC_W-1:0];
                REG_THRESHOLD:   thr_reg <= cfg_value;
                default: ;
            endcase
        end
    end

    // positions advance at accept; they do not depend on the weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            row_reg      <= '0;
            head_reg     <= '0;
            head_end_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            head_end_reg <= key_last && row_last;
            if (!key_last)
                key_reg <= key_reg + 1'b1;
            else
            begin
                key_reg <= '0;
                if (!row_last)
                    row_reg <= row_reg + 1'b1;
                else
                begin
                    row_reg  <= '0;
                    head_reg <= head_last ? '0 : head_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            w_reg        <= (in_weight > ONE_Q16) ? ONE_Q16 : in_weight;
            head_out_reg <= HN_W'(32'(head_reg));
        end
    end

    // leading-one position and table lookup -> -log2(w) in Q.16
    logic [4:0]  lead;
    logic [31:0] rem_w, idx_w;
    logic [LOG_TABLE_BITS-1:0] tab_idx;
    logic [NL_W-1:0] nl_next;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < W_W; i++)
        begin
            if (w_reg[i])
                lead = 5'(i);
        end
        rem_w = 32'(w_reg) & ~(32'd1 << lead);
        if (32'(lead) >= LOG_TABLE_BITS)
            idx_w = rem_w >> (32'(lead) - LOG_TABLE_BITS);
        else
            idx_w = rem_w << (LOG_TABLE_BITS - 32'(lead));
        tab_idx = idx_w[LOG_TABLE_BITS-1:0];
        nl_next = (NL_W'(5'd16 - lead) << 16) - NL_W'(log_tab[tab_idx]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.log_en)
            nl_reg <= nl_next;
        if (cmd.mul_en)
            prod_reg <= PROD_W'(w_reg) * PROD_W'(nl_reg);
    end

    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic [TC_W:0]    rem_shift;
    logic             rem_ge;

    assign sum_wide  = {1'b0, sum_reg} + (SUM_W+1)'(prod_reg[PROD_W-1:16]);
    assign sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign rem_shift = {rem_reg[TC_W-1:0], div_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, n_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (cmd.acc_en)
            sum_reg <= head_end_reg ? '0 : sum_sat;
    end

    // restoring divide, one quotient bit per cycle, shifted into div_reg
    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            div_reg  <= sum_sat;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_shift - {1'b0, n_eff} : rem_shift;
            div_reg  <= {div_reg[SUM_W-2:0], rem_ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    logic [ENT_W-1:0] ent_sat;
    assign ent_sat = (div_reg[SUM_W-1:ENT_W] != '0) ? {ENT_W{1'b1}} : div_reg[ENT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oval_reg <= 1'b0;
        else if (cmd.emit)
            oval_reg <= 1'b1;
        else if (out_ready)
            oval_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ohead_reg <= head_out_reg;
            oent_reg  <= ent_sat;
            oflag_reg <= (ent_sat < thr_reg) && (n_eff > COLLAPSE_MIN_N);
        end
    end

    assign status.head_end = head_end_reg;
    assign status.div_done = dcnt_reg == DCNT_W'(SUM_W - 1);
    assign status.out_free = !oval_reg || out_ready;

    assign out_valid   = oval_reg;
    assign out_head    = ohead_reg;
    assign out_entropy = oent_reg;
    assign out_flag    = oflag_reg;

endmodule

### test/attention_head_entropy_tb.sv
// Self-checking testbench for attention_head_entropy: directed table, random heads, predictor.
`timescale 1ns / 1ps

module attention_head_entropy_tb;

    import ahe_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 60;      // covers one item plus the divider
    localparam int RAND_ITEMS   = 1850;

    // packed from the top bit down, so it matches m_tdata[26:0]
    typedef struct packed {
        logic             collapse_flag;
        logic [ENT_W-1:0] entropy;
        logic [HN_W-1:0]  head_number;
    } head_result_t;

    typedef struct {
        logic [W_W-1:0]   weight;
        bit               typed;
        logic [ENT_W-1:0] entropy;
    } weight_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [THR_W-1:0]    cfg_data = '0;

    head_result_t        head_results_q[$];
    logic [15:0]         log_frac_tab[256];
    int                  fails = 0;
    int                  cycle = 0;
    int                  items_sent = 0;

    // predictor state
    logic [TC_W-1:0]     p_tokens;
    logic [HC_W-1:0]     p_heads;
    logic [THR_W-1:0]    p_thresh;
    int unsigned         p_key, p_row, p_head;
    logic [SUM_W-1:0]    p_sum;

    attention_head_entropy u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // quiet stretch: no idling on either side
    function automatic bit quiet();
        return cycle >= 3000 && cycle < 5500;
    endfunction

    function automatic logic [15:0] frac_log2(input int unsigned i);
        logic [63:0] x;
        logic [15:0] r;
        x = (64'd256 + 64'(i)) << 22;
        r = '0;
        for (int b = 15; b >= 0; b--)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                r[b] = 1'b1;
                x = x >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] neg_w_log2w(input logic [16:0] w);
        int m;
        logic [16:0] rem;
        logic [7:0]  ix;
        logic [20:0] nl;
        logic [37:0] prod;
        m = 16;
        while (m > 0 && !w[m])
            m--;
        rem = w - (17'd1 << m);
        if (m >= 8)
            ix = 8'(rem >> (m - 8));
        else
            ix = 8'(rem << (8 - m));
        nl = 21'((16 - m) * 65536) - 21'(log_frac_tab[ix]);
        prod = 38'(w) * 38'(nl);
        return SUM_W'(prod >> 16);
    endfunction

    // one accepted weight: advance positions, return 1 when a head closes
    function automatic bit entropy_predict(input logic [W_W-1:0] w_in,
                                           output head_result_t res);
        int unsigned n, hc;
        logic [W_W-1:0] w;
        logic [SUM_W:0] acc;
        logic [SUM_W-1:0] mean;
        n  = (p_tokens == 0) ? 1 : (p_tokens > MAX_TOKENS_DEF) ? MAX_TOKENS_DEF : p_tokens;
        hc = (p_heads == 0) ? 1 : (p_heads > MAX_HEADS_DEF) ? MAX_HEADS_DEF : p_heads;
        w  = (w_in > ONE_Q16) ? ONE_Q16 : w_in;
        res = '0;
        if (w != 0)
        begin
            acc = {1'b0, p_sum} + {1'b0, neg_w_log2w(w)};
            p_sum = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
        end
        if (p_key + 1 < n)
        begin
            p_key++;
            return 1'b0;
        end
        p_key = 0;
        if (p_row + 1 < n)
        begin
            p_row++;
            return 1'b0;
        end
        p_row = 0;
        mean = p_sum / SUM_W'(n);
        res.head_number   = HN_W'(p_head);
        res.entropy       = (mean > 34'hFFFFF) ? 20'hFFFFF : mean[ENT_W-1:0];
        res.collapse_flag = (res.entropy < p_thresh) && (n > 4);
        p_sum = '0;
        p_head = (p_head + 1 < hc) ? p_head + 1 : 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch @%0d: %s got %0d want %0d", cycle, what, got, want);
        fails++;
    endtask

    task automatic write_regs(input logic [TC_W-1:0] tc, input logic [HC_W-1:0] hc,
                              input logic [THR_W-1:0] thr);
        logic [IDX_W-1:0] idx[3];
        logic [THR_W-1:0] val[3];
        idx = '{REG_TOKEN_COUNT, REG_HEAD_COUNT, REG_THRESHOLD};
        val = '{THR_W'(tc), THR_W'(hc), thr};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        p_tokens = tc;
        p_heads  = hc;
        p_thresh = thr;
        @(posedge clk);
    endtask

    // drive one weight; valid stays high between back-to-back items
    task automatic send_weight(input logic [W_W-1:0] w, input bit typed,
                               input logic [ENT_W-1:0] typed_ent);
        head_result_t res;
        if (!quiet() && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (entropy_predict(w, res))
        begin
            if (typed)
            begin
                res.entropy = typed_ent;
                res.collapse_flag = 1'b0;
            end
            head_results_q = {head_results_q, res};
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (head_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    function automatic logic [W_W-1:0] row_weight(input int mode, input int n, input int k,
                                                  input int hot);
        case (mode)
            0: return (k == hot) ? ONE_Q16 : '0;
            1: return W_W'(65536 / n) + W_W'($urandom_range(0, 3));
            2: return W_W'($urandom_range(0, 65536));
            3: return W_W'($urandom);
            default: return '0;
        endcase
    endfunction

    // result side: random stalls, compare against oldest expectation
    always @(posedge clk)
    begin
        head_result_t got, want;
        cycle <= cycle + 1;
        m_tready <= quiet() ? 1'b1 : ($urandom_range(99) >= 15);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[26:0];
            if (head_results_q.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata, '0);
            end
            else
            begin
                want = head_results_q.pop_front();
                if (got.head_number != want.head_number)
                    report_mismatch("head_number", got.head_number, want.head_number);
                if (got.entropy != want.entropy)
                    report_mismatch("entropy", got.entropy, want.entropy);
                if (got.collapse_flag != want.collapse_flag)
                    report_mismatch("collapse_flag", got.collapse_flag, want.collapse_flag);
            end
        end
        if (cycle >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("** attention_head_entropy: FAILED **");
            $finish;
        end
    end

    initial
    begin
        weight_row_t dir_rows[$];
        int n, hc, mode, hot, sel;
        logic [TC_W-1:0] tc_pick;

        for (int i = 0; i < 256; i++)
            log_frac_tab[i] = frac_log2(i);
        p_tokens = TC_RESET;
        p_heads  = HC_RESET;
        p_thresh = THR_RESET;
        p_key = 0;
        p_row = 0;
        p_head = 0;
        p_sum = '0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: 4x4 head of uniform weights (16 items, one head)
        for (int i = 0; i < 16; i++)
            send_weight(W_W'(16384), 1'b0, '0);
        wait_idle();

        // one weight per head: zero, one, above one, half, tiny, near one
        write_regs(TC_W'(1), HC_W'(1), THR_W'(6554));
        dir_rows = '{
            '{17'd0,      1'b1, 20'd0},
            '{17'd65536,  1'b1, 20'd0},
            '{17'd131071, 1'b1, 20'd0},
            '{17'd98304,  1'b1, 20'd0},
            '{17'd32768,  1'b1, 20'd32768},
            '{17'd1,      1'b0, 20'd0},
            '{17'd2,      1'b0, 20'd0},
            '{17'd3,      1'b0, 20'd0},
            '{17'd255,    1'b0, 20'd0},
            '{17'd256,    1'b0, 20'd0},
            '{17'd257,    1'b0, 20'd0},
            '{17'd511,    1'b0, 20'd0},
            '{17'd24109,  1'b0, 20'd0},
            '{17'd65535,  1'b0, 20'd0},
            '{17'd43690,  1'b0, 20'd0}
        };
        foreach (dir_rows[i])
            send_weight(dir_rows[i].weight, dir_rows[i].typed, dir_rows[i].entropy);
        wait_idle();

        // zero counts act as one; threshold at its top
        write_regs('0, '0, 20'hFFFFF);
        for (int i = 0; i < 3; i++)
            send_weight(W_W'($urandom_range(1, 65535)), 1'b0, '0);
        wait_idle();

        // collapsed heads with n = 5: one-hot rows, threshold at top
        write_regs(TC_W'(5), HC_W'(127), 20'hFFFFF);
        for (int i = 0; i < 25; i++)
            send_weight((i % 5 == 0) ? ONE_Q16 : '0, 1'b0, '0);
        wait_idle();

        // token counts at and above the limit, then a shrink that ends the row mid-stream
        write_regs(TC_W'(4096), HC_W'(64), '0);
        for (int i = 0; i < 7; i++)
            send_weight(W_W'($urandom_range(0, 65536)), 1'b0, '0);
        wait_idle();
        write_regs(TC_W'(8191), HC_W'(2), 20'd100);
        for (int i = 0; i < 5; i++)
            send_weight(W_W'($urandom_range(0, 65536)), 1'b0, '0);
        wait_idle();
        write_regs(TC_W'(2), HC_W'(3), THR_RESET);
        for (int i = 0; i < 12; i++)
            send_weight(W_W'($urandom_range(0, 65536)), 1'b0, '0);
        wait_idle();

        items_sent = 0;
        while (items_sent < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                tc_pick = TC_W'($urandom_range(9, 8191));
            else
                tc_pick = TC_W'($urandom_range(1, 8));
            write_regs(tc_pick, HC_W'($urandom_range(0, 127)),
                       ($urandom_range(0, 3) == 0) ? THR_W'($urandom)
                                                   : THR_W'($urandom_range(0, 200000)));
            n = (tc_pick == 0) ? 1 : tc_pick;
            if (n > 8)
            begin
                // huge head: a few weights only, left open
                for (int i = 0; i < $urandom_range(1, 10); i++)
                    send_weight(W_W'($urandom), 1'b0, '0);
            end
            else
            begin
                hc = $urandom_range(1, 4);
                for (int h = 0; h < hc; h++)
                    for (int r = 0; r < n; r++)
                    begin
                        mode = $urandom_range(0, 9);
                        mode = (mode < 3) ? 0 : (mode < 5) ? 1 : (mode < 7) ? 2 :
                               (mode < 9) ? 3 : 4;
                        hot = $urandom_range(0, n - 1);
                        for (int k = 0; k < n; k++)
                            send_weight(row_weight(mode, n, k, hot), 1'b0, '0);
                    end
                // occasional stray items leave a head open for the next setting
                if ($urandom_range(0, 4) == 0)
                    for (int i = 0; i < $urandom_range(1, 5); i++)
                        send_weight(W_W'($urandom), 1'b0, '0);
            end
            wait_idle();
        end

        if (fails == 0)
            $display("** attention_head_entropy: PASSED **");
        else
            $display("** attention_head_entropy: FAILED **");
        $finish;
    end

endmodule
